>>> hdl/rxrlpp_pkg.sv
// ----------------------------------------------------------------------------
// rxrlpp_pkg
// shared types and codes for the receive ring with line extraction and peek
// ----------------------------------------------------------------------------
package rxrlpp_pkg;

	typedef enum logic [1:0] {
		ACT_PUSH    = 2'd0,
		ACT_POP     = 2'd1,
		ACT_EXTRACT = 2'd2,
		ACT_PEEK    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_ERROR    = 2'd3
	} status_t;

	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_UPA   = 8'h41;
	localparam logic [7:0] CHAR_UPZ   = 8'h5a;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	localparam logic [2:0] REG_PATTERN_CHARS  = 3'd0;
	localparam logic [2:0] REG_PATTERN_LENGTH = 3'd1;
	localparam logic [2:0] REG_COPY_LIMIT     = 3'd2;

	function automatic logic [7:0] fold_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CHAR_UPA && c <= CHAR_UPZ) begin
			r = c + CASE_DELTA;
		end
		return r;
	endfunction

endpackage

>>> hdl/rx_ring_line_and_pattern_peek.sv
// ----------------------------------------------------------------------------
// rx_ring_line_and_pattern_peek
// receive ring buffer with push, pop, line extraction and pattern peek
// ----------------------------------------------------------------------------
// push: result in the cycle after the word is taken; next word waits until it is accepted
// pop: S_RD, S_POP around the registered ring read; no new word until the result is taken
// extract: S_XRD/S_XCHK per ring byte walked, S_LRD/S_LOUT per word, one ring read port
// peek: S_PRD/S_PCHK per byte compared, up to (unread - length + 1) x length compares
// reset: indices and line count cleared, registers to defaults; the ring and
// line memories are not cleared and need no clearing pass
module rx_ring_line_and_pattern_peek #(
	parameter int RING_DEPTH  = 512,
	parameter int LINE_DEPTH  = 64,
	parameter int PATTERN_MAX = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  rx_byte,
	input  logic        frame_error,
	input  logic        noise_error,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  data_byte,
	output logic [1:0]  status,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int RW = $clog2(RING_DEPTH);
	localparam int LW = $clog2(LINE_DEPTH);
	localparam int CW = $clog2(LINE_DEPTH + 1);
	localparam int PW = $clog2(PATTERN_MAX + 1);
	localparam int KW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_RD    = 10'b0000000010,
		S_POP   = 10'b0000000100,
		S_XRD   = 10'b0000001000,
		S_XCHK  = 10'b0000010000,
		S_LRD   = 10'b0000100000,
		S_LOUT  = 10'b0001000000,
		S_PRD   = 10'b0010000000,
		S_PCHK  = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [63:0] pat_q;
	logic [3:0]  plen_q;
	logic [6:0]  climit_q;

	logic [7:0] ring_mem [RING_DEPTH];
	logic [7:0] line_mem [LINE_DEPTH];
	logic [7:0] ring_rd_q;
	logic [7:0] line_rd_q;

	logic [RW-1:0] wr_idx_q, rd_idx_q, scan_q;
	logic [CW-1:0] lcnt_q, emit_q, nemit_q;
	logic [PW-1:0] k_q, len_q;
	logic [RW:0]   starts_q;

	logic       ov_q;
	logic [7:0] od_q;
	logic [1:0] os_q;
	logic       ol_q;

	logic in_acc, out_acc, cfg_wr;
	logic [RW:0] unread;
	logic [RW-1:0] wr_next;
	logic [7:0] pat_byte;
	logic [6:0] lim1;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (state_q != S_IDLE) || ov_q;
	assign out_valid = ov_q;
	assign data_byte = od_q;
	assign status = os_q;
	assign last = ol_q;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	assign wr_next = (wr_idx_q == RW'(RING_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
	assign unread = (wr_idx_q >= rd_idx_q) ? (RW+1)'(wr_idx_q - rd_idx_q)
		: (RW+1)'(RING_DEPTH) - (RW+1)'(rd_idx_q) + (RW+1)'(wr_idx_q);
	assign pat_byte = pat_q[8*k_q[KW-1:0] +: 8];
	assign lim1 = (climit_q == 7'd0) ? 7'd0 : climit_q - 7'd1;

	function automatic logic [RW-1:0] inc(input logic [RW-1:0] v);
		return (v == RW'(RING_DEPTH - 1)) ? '0 : v + 1'b1;
	endfunction

	always_comb begin
		prdata = '0;
		unique case ({1'b0, paddr[4:3]})
			rxrlpp_pkg::REG_PATTERN_CHARS:  prdata = pat_q;
			rxrlpp_pkg::REG_PATTERN_LENGTH: prdata = 64'(plen_q);
			rxrlpp_pkg::REG_COPY_LIMIT:     prdata = 64'(climit_q);
			default:                        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			plen_q <= '0;
			climit_q <= 7'd64;
		end else if (cfg_wr) begin
			unique case ({1'b0, paddr[4:3]})
				rxrlpp_pkg::REG_PATTERN_CHARS:  pat_q <= pwdata;
				rxrlpp_pkg::REG_PATTERN_LENGTH: plen_q <= pwdata[3:0];
				rxrlpp_pkg::REG_COPY_LIMIT:     climit_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// memories
	logic ring_we, line_we;
	logic [RW-1:0] ring_ra;
	logic [LW-1:0] line_ra;
	assign ring_we = in_acc && (action == rxrlpp_pkg::ACT_PUSH) && !frame_error
		&& !noise_error && (wr_next != rd_idx_q);
	assign line_we = (state_q == S_XCHK) && (ring_rd_q != rxrlpp_pkg::CHAR_CR)
		&& (ring_rd_q != rxrlpp_pkg::CHAR_LF);

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[wr_idx_q] <= rx_byte;
		end
		ring_rd_q <= ring_mem[ring_ra];
		if (line_we) begin
			line_mem[lcnt_q[LW-1:0]] <= ring_rd_q;
		end
		line_rd_q <= line_mem[line_ra];
	end

	always_comb begin
		ring_ra = rd_idx_q;
		if (state_q == S_PRD) begin
			ring_ra = scan_q;
		end
		line_ra = emit_q[LW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			lcnt_q <= '0;
			ov_q <= 1'b0;
			od_q <= '0;
			os_q <= '0;
			ol_q <= 1'b0;
			scan_q <= '0;
			emit_q <= '0;
			nemit_q <= '0;
			k_q <= '0;
			len_q <= '0;
			starts_q <= '0;
		end else begin
			if (out_acc) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						od_q <= '0;
						ol_q <= 1'b1;
						case (action)
							rxrlpp_pkg::ACT_PUSH: begin
								ov_q <= 1'b1;
								if (frame_error || noise_error) begin
									os_q <= rxrlpp_pkg::ST_ERROR;
								end else if (wr_next == rd_idx_q) begin
									os_q <= rxrlpp_pkg::ST_FULL;
								end else begin
									os_q <= rxrlpp_pkg::ST_DONE;
									wr_idx_q <= wr_next;
								end
							end
							rxrlpp_pkg::ACT_POP: begin
								if (unread == '0) begin
									ov_q <= 1'b1;
									os_q <= rxrlpp_pkg::ST_EMPTY;
								end else begin
									state_q <= S_RD;
								end
							end
							rxrlpp_pkg::ACT_EXTRACT: begin
								lcnt_q <= '0;
								state_q <= S_XRD;
							end
							default: begin
								len_q <= (plen_q > 4'(PATTERN_MAX)) ? PW'(PATTERN_MAX)
									: PW'(plen_q);
								scan_q <= rd_idx_q;
								k_q <= '0;
								if (plen_q == 4'd0 || unread < (RW+1)'((plen_q >
									4'(PATTERN_MAX)) ? 4'(PATTERN_MAX) : plen_q)) begin
									ov_q <= 1'b1;
									os_q <= rxrlpp_pkg::ST_EMPTY;
								end else begin
									starts_q <= unread - (RW+1)'((plen_q >
										4'(PATTERN_MAX)) ? 4'(PATTERN_MAX) : plen_q);
									state_q <= S_PRD;
								end
							end
						endcase
					end
				end
				S_RD: state_q <= S_POP;
				S_POP: begin
					od_q <= ring_rd_q;
					os_q <= rxrlpp_pkg::ST_DONE;
					ol_q <= 1'b1;
					ov_q <= 1'b1;
					rd_idx_q <= inc(rd_idx_q);
					state_q <= S_IDLE;
				end
				S_XRD: begin
					if (rd_idx_q == wr_idx_q || lcnt_q >= CW'(LINE_DEPTH - 1)) begin
						od_q <= '0;
						os_q <= rxrlpp_pkg::ST_EMPTY;
						ol_q <= 1'b1;
						ov_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_XCHK;
					end
				end
				S_XCHK: begin
					rd_idx_q <= inc(rd_idx_q);
					state_q <= S_XRD;
					if (ring_rd_q == rxrlpp_pkg::CHAR_CR || ring_rd_q == rxrlpp_pkg::CHAR_LF) begin
						if (lcnt_q != '0) begin
							emit_q <= '0;
							nemit_q <= (CW'(lim1) < lcnt_q) ? CW'(lim1) : lcnt_q;
							state_q <= S_LRD;
						end
					end else begin
						lcnt_q <= lcnt_q + 1'b1;
					end
				end
				S_LRD: begin
					if (!ov_q || out_acc) begin
						state_q <= S_LOUT;
					end
				end
				S_LOUT: begin
					ov_q <= 1'b1;
					os_q <= rxrlpp_pkg::ST_DONE;
					if (emit_q == nemit_q) begin
						od_q <= '0;
						ol_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						od_q <= line_rd_q;
						ol_q <= 1'b0;
						emit_q <= emit_q + 1'b1;
						state_q <= S_LRD;
					end
				end
				S_PRD: state_q <= S_PCHK;
				S_PCHK: begin
					if (rxrlpp_pkg::fold_lower(ring_rd_q) == pat_byte) begin
						if (k_q + 1'b1 == len_q) begin
							ov_q <= 1'b1;
							od_q <= '0;
							ol_q <= 1'b1;
							os_q <= rxrlpp_pkg::ST_DONE;
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
							scan_q <= inc(scan_q);
							state_q <= S_PRD;
						end
					end else if (starts_q == '0) begin
						ov_q <= 1'b1;
						od_q <= '0;
						ol_q <= 1'b1;
						os_q <= rxrlpp_pkg::ST_EMPTY;
						state_q <= S_IDLE;
					end else begin
						// next start: rewind to start+1
						scan_q <= (scan_q >= RW'(k_q)) ? inc(scan_q - RW'(k_q))
							: inc(RW'(RING_DEPTH) - RW'(k_q) + scan_q);
						k_q <= '0;
						starts_q <= starts_q - 1'b1;
						state_q <= S_PRD;
					end
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && out_stall |=> ov_q) else $error("result lost while stalled");
	a_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("input taken while busy");
	a_line_cap: assert property (@(posedge clk) disable iff (!arst_n)
		lcnt_q <= CW'(LINE_DEPTH - 1)) else $error("line count overrun");

endmodule

>>> bench/rx_ring_line_and_pattern_peek_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_ring_line_and_pattern_peek_chk
// Watches the input, output and register ports of the receive ring. It keeps
// its own copy of the ring and registers, gathers each line itself, works out the words each
// accepted action gives, and checks every output word in order.
// ----------------------------------------------------------------------------
module rx_ring_line_and_pattern_peek_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  rx_byte,
	input  logic        frame_error,
	input  logic        noise_error,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  data_byte,
	input  logic [1:0]  status,
	input  logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [7:0]          data;
		rxrlpp_pkg::status_t st;
		logic                fin;
	} ring_word_t;

	ring_word_t  expected_words[$];
	logic [7:0]  ring_mem [512];
	logic [8:0]  wr_ptr;
	logic [8:0]  rd_ptr;
	logic [63:0] pat_chars;
	logic [3:0]  pat_len;
	logic [6:0]  copy_lim;

	function automatic ring_word_t mk(logic [7:0] d, rxrlpp_pkg::status_t s, logic f);
		ring_word_t w;
		w.data = d;
		w.st = s;
		w.fin = f;
		return w;
	endfunction

	task automatic predict_extract();
		logic [7:0] gathered [64];
		logic [7:0] c;
		int cnt;
		int lim;
		int n;
		bit done;
		cnt = 0;
		done = 0;
		while (rd_ptr != wr_ptr && cnt < 63) begin
			c = ring_mem[rd_ptr];
			rd_ptr = rd_ptr + 9'd1;
			if (c == rxrlpp_pkg::CHAR_CR || c == rxrlpp_pkg::CHAR_LF) begin
				if (cnt > 0) begin
					done = 1;
					break;
				end
			end else begin
				gathered[cnt] = c;
				cnt++;
			end
		end
		if (!done) begin
			expected_words.push_back(mk(8'd0, rxrlpp_pkg::ST_EMPTY, 1'b1));
		end else begin
			lim = (copy_lim == 0) ? 1 : int'(copy_lim);
			n = (cnt > lim - 1) ? lim - 1 : cnt;
			for (int k = 0; k < n; k++)
				expected_words.push_back(mk(gathered[k], rxrlpp_pkg::ST_DONE, 1'b0));
			expected_words.push_back(mk(8'd0, rxrlpp_pkg::ST_DONE, 1'b1));
		end
	endtask

	function automatic bit pattern_present();
		int len;
		int avail;
		logic [7:0] c;
		bit ok;
		len = (pat_len > 8) ? 8 : int'(pat_len);
		avail = int'(9'(wr_ptr - rd_ptr));
		if (len == 0 || avail < len)
			return 0;
		for (int s = 0; s + len <= avail; s++) begin
			ok = 1;
			for (int k = 0; k < len; k++) begin
				c = ring_mem[9'(rd_ptr + s + k)];
				if (c >= 8'h41 && c <= 8'h5a)
					c = c + 8'h20;
				if (c != pat_chars[8*k +: 8]) begin
					ok = 0;
					break;
				end
			end
			if (ok)
				return 1;
		end
		return 0;
	endfunction

	task automatic predict(rxrlpp_pkg::action_t a, logic [7:0] b, logic fe, logic ne);
		case (a)
			rxrlpp_pkg::ACT_PUSH: begin
				if (fe || ne) begin
					expected_words.push_back(mk(8'd0, rxrlpp_pkg::ST_ERROR, 1'b1));
				end else if (9'(wr_ptr + 9'd1) == rd_ptr) begin
					expected_words.push_back(mk(8'd0, rxrlpp_pkg::ST_FULL, 1'b1));
				end else begin
					ring_mem[wr_ptr] = b;
					wr_ptr = wr_ptr + 9'd1;
					expected_words.push_back(mk(8'd0, rxrlpp_pkg::ST_DONE, 1'b1));
				end
			end
			rxrlpp_pkg::ACT_POP: begin
				if (rd_ptr == wr_ptr) begin
					expected_words.push_back(mk(8'd0, rxrlpp_pkg::ST_EMPTY, 1'b1));
				end else begin
					expected_words.push_back(mk(ring_mem[rd_ptr], rxrlpp_pkg::ST_DONE, 1'b1));
					rd_ptr = rd_ptr + 9'd1;
				end
			end
			rxrlpp_pkg::ACT_EXTRACT: begin
				predict_extract();
			end
			default: begin
				expected_words.push_back(mk(8'd0, pattern_present() ? rxrlpp_pkg::ST_DONE
					: rxrlpp_pkg::ST_EMPTY, 1'b1));
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		ring_word_t w;
		int errs;
		if (!arst_n) begin
			wr_ptr = '0;
			rd_ptr = '0;
			pat_chars = '0;
			pat_len = '0;
			copy_lim = 7'd64;
			expected_words.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			errs = 0;
			if (psel && penable && pwrite && pready) begin
				if (paddr[4:3] == 2'(rxrlpp_pkg::REG_PATTERN_CHARS))
					pat_chars = pwdata;
				else if (paddr[4:3] == 2'(rxrlpp_pkg::REG_PATTERN_LENGTH))
					pat_len = pwdata[3:0];
				else if (paddr[4:3] == 2'(rxrlpp_pkg::REG_COPY_LIMIT))
					copy_lim = pwdata[6:0];
			end
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word: data %0h status %0d last %0b",
						data_byte, status, last);
					errs++;
				end else begin
					w = expected_words.pop_front();
					if (data_byte !== w.data) begin
						$error("data_byte: expected %0h actual %0h", w.data, data_byte);
						errs++;
					end
					if (status !== w.st) begin
						$error("status: expected %0d actual %0d", w.st, status);
						errs++;
					end
					if (last !== w.fin) begin
						$error("last: expected %0b actual %0b", w.fin, last);
						errs++;
					end
				end
			end
			if (in_valid && !in_stall)
				predict(rxrlpp_pkg::action_t'(action), rx_byte, frame_error, noise_error);
			fail_count <= fail_count + errs;
			pending <= expected_words.size();
		end
	end

endmodule

>>> bench/rx_ring_line_and_pattern_peek_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_ring_line_and_pattern_peek_tb
// Drives pushes, pops, line extracts and pattern peeks into the receive ring
// under several register settings, with random idling on both sides, a long
// output hold-off and a line with no end; the checker gives the verdict.
// ----------------------------------------------------------------------------
module rx_ring_line_and_pattern_peek_tb;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [7:0]  rx_byte;
	logic        frame_error;
	logic        noise_error;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  data_byte;
	logic [1:0]  status;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;

	bit          calm;
	bit          hold_req;
	int          quiet_cycles;
	logic [63:0] cur_pat;
	int          cur_len;

	rx_ring_line_and_pattern_peek dut (.*);

	rx_ring_line_and_pattern_peek_chk chk (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("rx_ring_line_and_pattern_peek_tb failed");
			$finish;
		end
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_req = 0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	task automatic send_word(rxrlpp_pkg::action_t a, logic [7:0] b, logic fe, logic ne);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		rx_byte <= b;
		frame_error <= fe;
		noise_error <= ne;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx * 8);
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_pattern(logic [63:0] chars, int len);
		cur_pat = chars;
		cur_len = (len > 8) ? 8 : len;
		write_reg(rxrlpp_pkg::REG_PATTERN_CHARS, chars);
		write_reg(rxrlpp_pkg::REG_PATTERN_LENGTH, 64'(len));
	endtask

	function automatic logic [7:0] text_char();
		int r;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 12)
			return ($urandom_range(0, 1) != 0) ? rxrlpp_pkg::CHAR_CR : rxrlpp_pkg::CHAR_LF;
		if (r < 22)
			return 8'($urandom);
		if (r < 55 && cur_len > 0) begin
			c = cur_pat[8 * $urandom_range(0, cur_len - 1) +: 8];
			if (c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 1) != 0)
				c = c - rxrlpp_pkg::CASE_DELTA;
			return c;
		end
		c = 8'h61 + 8'($urandom_range(0, 25));
		return ($urandom_range(0, 1) != 0) ? c - rxrlpp_pkg::CASE_DELTA : c;
	endfunction

	task automatic random_words(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				send_word(rxrlpp_pkg::action_t'($urandom_range(0, 3)), 8'($urandom),
					1'($urandom), 1'($urandom));
			else if (r < 55)
				send_word(rxrlpp_pkg::ACT_PUSH, text_char(), $urandom_range(0, 19) == 0,
					$urandom_range(0, 19) == 0);
			else if (r < 68)
				send_word(rxrlpp_pkg::ACT_POP, 8'($urandom), 1'b0, 1'b0);
			else if (r < 86)
				send_word(rxrlpp_pkg::ACT_EXTRACT, 8'($urandom), 1'b0, 1'b0);
			else
				send_word(rxrlpp_pkg::ACT_PEEK, 8'($urandom), 1'b0, 1'b0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = rxrlpp_pkg::ACT_PUSH;
		rx_byte = '0;
		frame_error = 1'b0;
		noise_error = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm = 0;
		hold_req = 0;
		cur_pat = '0;
		cur_len = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty ring, errors, folding, edge bytes, line handling
		send_word(rxrlpp_pkg::ACT_POP, 8'h00, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_EXTRACT, 8'h00, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_PEEK, 8'h00, 1'b0, 1'b0);
		wait_idle();
		set_pattern(64'h6b6f, 2);
		send_word(rxrlpp_pkg::ACT_PEEK, 8'h00, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_PUSH, 8'h4f, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_PUSH, 8'h4b, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_PUSH, 8'h21, 1'b1, 1'b0);
		send_word(rxrlpp_pkg::ACT_PUSH, 8'h22, 1'b0, 1'b1);
		send_word(rxrlpp_pkg::ACT_PUSH, 8'hff, 1'b1, 1'b1);
		send_word(rxrlpp_pkg::ACT_PEEK, 8'h00, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_PUSH, rxrlpp_pkg::CHAR_CR, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_PUSH, rxrlpp_pkg::CHAR_LF, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_PUSH, 8'h00, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_PUSH, 8'hff, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_PUSH, rxrlpp_pkg::CHAR_LF, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_PUSH, rxrlpp_pkg::CHAR_CR, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_PUSH, 8'h61, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_POP, 8'h00, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_EXTRACT, 8'h00, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_EXTRACT, 8'h00, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_EXTRACT, 8'h00, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_POP, 8'h00, 1'b0, 1'b0);
		wait_idle();

		write_reg(rxrlpp_pkg::REG_COPY_LIMIT, 64'd3);
		set_pattern(64'h6f6c_6c65_68, 5);
		random_words(20);

		// long output hold-off while the sender keeps offering words
		hold_req = 1;
		for (int i = 0; i < 15; i++)
			send_word(rxrlpp_pkg::ACT_PUSH, text_char(), 1'b0, 1'b0);
		wait_idle();

		write_reg(rxrlpp_pkg::REG_COPY_LIMIT, 64'd0);
		set_pattern({8'h00, 56'h61_6263_6465_6667}, 12);
		random_words(15);
		wait_idle();

		// long line with no end
		write_reg(rxrlpp_pkg::REG_COPY_LIMIT, 64'd64);
		set_pattern(64'h7a79, 2);
		for (int i = 0; i < 64; i++)
			send_word(rxrlpp_pkg::ACT_PUSH, 8'h61 + 8'($urandom_range(0, 25)), 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_PEEK, 8'h00, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_EXTRACT, 8'h00, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_POP, 8'h00, 1'b0, 1'b0);
		send_word(rxrlpp_pkg::ACT_POP, 8'h00, 1'b0, 1'b0);
		wait_idle();

		write_reg(rxrlpp_pkg::REG_COPY_LIMIT, 64'd1);
		set_pattern(64'hffff_ffff_ffff_ffff, 8);
		random_words(8);
		wait_idle();

		write_reg(rxrlpp_pkg::REG_COPY_LIMIT, 64'd127);
		set_pattern(64'h6e6f, 2);
		calm = 1;
		random_words(8);
		wait_idle();
		repeat (50) @(posedge clk);

		if (fail_count == 0)
			$display("rx_ring_line_and_pattern_peek_tb passed");
		else
			$display("rx_ring_line_and_pattern_peek_tb failed");
		$finish;
	end

endmodule
